### src/lfu_cache_table_top_defines.svh
// Assertion macros for the LFU cache table
`ifndef LFU_CACHE_TABLE_TOP_DEFINES_SVH
`define LFU_CACHE_TABLE_TOP_DEFINES_SVH
// same-cycle implication
`define LFU_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lfu check failed");
// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lfu check failed");
`endif

### src/lfu_pkg.sv
// Shared constants and types for the LFU cache table
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int OccW = $clog2(Entries + 1);
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              vld;
    logic [31:0]       key;
    logic              m_found;
    logic [IdxW-1:0]   m_idx;
    logic [31:0]       m_data;
    logic              v_found;
    logic [IdxW-1:0]   v_idx;
    logic [31:0]       v_key;
    logic [31:0]       v_cnt;
    logic [63:0]       v_stamp;
    logic              f_found;
    logic [IdxW-1:0]   f_idx;
    logic [OccW-1:0]   occ;
  } scan_t;

  typedef struct packed {
    logic              vld;
    logic [IdxW-1:0]   slot;
    logic              insert;
    logic              set_data;
    logic [31:0]       key;
    logic [31:0]       data;
    logic [63:0]       stamp;
  } wcmd_t;
endpackage
`default_nettype wire

### src/lfu_cell.sv
// One cache entry; folds its entry into the passing scan request and applies writes
`timescale 1ns / 1ps
`default_nettype none
module lfu_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [lfu_pkg::IdxW-1:0] idx,
  input  wire lfu_pkg::scan_t        scan_in,
  output lfu_pkg::scan_t             scan_out,
  input  wire lfu_pkg::wcmd_t        wcmd
);
  import lfu_pkg::*;

  logic        valid_r;
  logic [31:0] key_r, data_r, cnt_r;
  logic [63:0] stamp_r;
  scan_t       scan_r, scan_nxt;
  logic        sel;

  assign sel = wcmd.vld && (wcmd.slot == idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && wcmd.insert) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= wcmd.stamp;
      if (wcmd.insert) begin
        key_r <= wcmd.key;
        cnt_r <= 32'd1;
      end else if (cnt_r != 32'hFFFF_FFFF) begin
        cnt_r <= cnt_r + 32'd1;
      end
      if (wcmd.insert || wcmd.set_data) begin
        data_r <= wcmd.data;
      end
    end
  end

  always_comb begin
    scan_nxt = scan_in;
    if (scan_in.vld) begin
      if (!valid_r) begin
        if (!scan_in.f_found) begin
          scan_nxt.f_found = 1'b1;
          scan_nxt.f_idx = idx;
        end
      end else begin
        scan_nxt.occ = scan_in.occ + OccW'(1);
        if (key_r == scan_in.key && !scan_in.m_found) begin
          scan_nxt.m_found = 1'b1;
          scan_nxt.m_idx = idx;
          scan_nxt.m_data = data_r;
        end
        if (!scan_in.v_found || cnt_r < scan_in.v_cnt ||
            (cnt_r == scan_in.v_cnt && stamp_r < scan_in.v_stamp)) begin
          scan_nxt.v_found = 1'b1;
          scan_nxt.v_idx = idx;
          scan_nxt.v_key = key_r;
          scan_nxt.v_cnt = cnt_r;
          scan_nxt.v_stamp = stamp_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.vld <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;
endmodule
`default_nettype wire

### src/lfu_cache_table_top.sv
// Top level of the LFU cache table: cell chain, control and result register
//  channel | ports                                   | direction
//  in      | in_valid in_stall in_req_type in_lookup_key in_write_value | request in
//  out     | out_valid out_stall out_hit out_read_value out_evicted out_evicted_key | result out
//  cfg     | cfg_we cfg_data                         | capacity write
// From accept to out_valid a request passes one register per cell of the chain, with the
// decision made while the last cell's output loads the result register.
// A new request is taken only once the result has been taken and the block is back in idle,
// so an output stall holds off the next accept.
// One request at a time; in_stall is high from accept until the result is taken.
// Reset empties all entries, clears the stamp counter and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_table_top_defines.svh"
module lfu_cache_table_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic signed [31:0] in_lookup_key,
  input  wire logic signed [31:0] in_write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic signed [31:0] out_read_value,
  output logic             out_evicted,
  output logic signed [31:0] out_evicted_key,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_data
);
  import lfu_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [4:0]  cap_r;
  logic [4:0]  cap_eff;
  logic [63:0] stamp_r;
  logic        put_r;
  logic [31:0] wval_r;
  wcmd_t       wcmd_r, wcmd_nxt;
  scan_t       scan_head;
  scan_t       chain [Entries+1];
  scan_t       last;
  logic        hit_nxt, ev_nxt;
  logic [31:0] rd_nxt, evk_nxt;
  logic        accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != StIdle);

  always_comb begin
    scan_head = '0;
    scan_head.vld = accept;
    scan_head.key = in_lookup_key;
  end

  assign chain[0] = scan_head;

  genvar g;
  generate
    for (g = 0; g < Entries; g++) begin : g_cell
      lfu_cell u_cell (
        .clk(clk), .rst_n(rst_n), .idx(IdxW'(g)),
        .scan_in(chain[g]), .scan_out(chain[g+1]), .wcmd(wcmd_r)
      );
    end
  endgenerate

  assign last = chain[Entries];
  assign cap_eff = (cap_r > 5'(Entries)) ? 5'(Entries) : cap_r;

  always_comb begin
    wcmd_nxt = '0;
    wcmd_nxt.key = last.key;
    wcmd_nxt.data = wval_r;
    wcmd_nxt.stamp = stamp_r;
    hit_nxt = last.m_found;
    rd_nxt = MissValue;
    ev_nxt = 1'b0;
    evk_nxt = '0;
    if (!put_r) begin
      if (last.m_found) begin
        wcmd_nxt.vld = 1'b1;
        wcmd_nxt.slot = last.m_idx;
        rd_nxt = last.m_data;
      end
    end else if (cap_eff != 5'd0) begin
      if (last.m_found) begin
        wcmd_nxt.vld = 1'b1;
        wcmd_nxt.slot = last.m_idx;
        wcmd_nxt.set_data = 1'b1;
      end else if ((5'(last.occ) >= cap_eff) && last.v_found) begin
        wcmd_nxt.vld = 1'b1;
        wcmd_nxt.insert = 1'b1;
        wcmd_nxt.slot = last.v_idx;
        ev_nxt = 1'b1;
        evk_nxt = last.v_key;
      end else if (last.f_found) begin
        wcmd_nxt.vld = 1'b1;
        wcmd_nxt.insert = 1'b1;
        wcmd_nxt.slot = last.f_idx;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      StIdle: if (accept) state_nxt = StScan;
      StScan: if (last.vld) state_nxt = StOut;
      StOut:  if (!out_stall) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cap_r <= 5'd16;
      stamp_r <= '0;
      wcmd_r.vld <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_data;
      wcmd_r <= (state_r == StScan && last.vld) ? wcmd_nxt : '0;
      if (state_r == StScan && last.vld && wcmd_nxt.vld) stamp_r <= stamp_r + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      put_r <= in_req_type;
      wval_r <= in_write_value;
    end
    if (state_r == StScan && last.vld) begin
      out_hit <= hit_nxt;
      out_read_value <= rd_nxt;
      out_evicted <= ev_nxt;
      out_evicted_key <= evk_nxt;
    end
  end

  assign out_valid = (state_r == StOut);

  `LFU_ASSERT_NOW(a_noev_key, out_valid && !out_evicted, out_evicted_key == 32'sd0)
  `LFU_ASSERT_NOW(a_busy_out, out_valid, in_stall)
  `LFU_ASSERT_NEXT(a_wr_then_out, wcmd_r.vld, state_r == StOut || state_r == StIdle)
  `LFU_ASSERT_NOW(a_ev_put, out_valid && out_evicted, put_r && !out_hit)
endmodule
`default_nettype wire

### test/lfu_cache_table_top_tb.sv
// Self-checking testbench for the LFU cache table: directed table, then random requests
`timescale 1ns / 1ps
module lfu_cache_table_top_tb;
  localparam int NSLOT = 16;
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;
  localparam int RAND_ITEMS = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hit;
    logic [31:0] rd;
    logic        ev;
    logic [31:0] ev_key;
  } resp_t;

  typedef struct {
    logic        cfg;
    logic [4:0]  cap;
    logic        op;
    logic [31:0] key;
    logic [31:0] val;
    logic        known;
    resp_t       rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic signed [31:0] in_lookup_key = '0;
  logic signed [31:0] in_write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [31:0] out_read_value;
  logic out_evicted;
  logic signed [31:0] out_evicted_key;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;

  lfu_cache_table_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_lookup_key(in_lookup_key), .in_write_value(in_write_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_read_value(out_read_value), .out_evicted(out_evicted),
    .out_evicted_key(out_evicted_key), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic        m_vld [NSLOT];
  logic [31:0] m_key [NSLOT];
  logic [31:0] m_dat [NSLOT];
  logic [31:0] m_cnt [NSLOT];
  logic [63:0] m_stp [NSLOT];
  logic [63:0] m_clk;
  logic [4:0]  m_cap;

  resp_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_rx = 1'b0;

  function automatic resp_t lfu_access(logic op, logic [31:0] key, logic [31:0] val);
    resp_t r;
    int match, victim, free_s, slot;
    int occ, cap;
    r = '{hit: 1'b0, rd: 32'hFFFF_FFFF, ev: 1'b0, ev_key: 32'h0};
    match = -1; victim = -1; free_s = -1; occ = 0;
    cap = (m_cap > NSLOT) ? NSLOT : int'(m_cap);
    for (int i = 0; i < NSLOT; i++) begin
      if (!m_vld[i]) begin
        if (free_s < 0) free_s = i;
        continue;
      end
      occ++;
      if (m_key[i] == key && match < 0) match = i;
      if (victim < 0 || m_cnt[i] < m_cnt[victim] ||
          (m_cnt[i] == m_cnt[victim] && m_stp[i] < m_stp[victim])) victim = i;
    end
    r.hit = (match >= 0);
    if (op == REQ_GET) begin
      if (match >= 0) begin
        r.rd = m_dat[match];
        if (m_cnt[match] != 32'hFFFF_FFFF) m_cnt[match]++;
        m_stp[match] = m_clk; m_clk++;
      end
    end else if (cap != 0) begin
      if (match >= 0) begin
        m_dat[match] = val;
        if (m_cnt[match] != 32'hFFFF_FFFF) m_cnt[match]++;
        m_stp[match] = m_clk; m_clk++;
      end else begin
        slot = free_s;
        if (occ >= cap && victim >= 0) begin
          r.ev = 1'b1; r.ev_key = m_key[victim]; slot = victim;
        end
        if (slot >= 0) begin
          m_vld[slot] = 1'b1; m_key[slot] = key; m_dat[slot] = val;
          m_cnt[slot] = 32'd1; m_stp[slot] = m_clk; m_clk++;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(logic op, logic [31:0] key, logic [31:0] val);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1'b1; in_req_type <= op; in_lookup_key <= key; in_write_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.insert(expected_q.size(), lfu_access(op, key, val));
    in_valid <= 1'b0;
  endtask

  task automatic set_capacity(logic [4:0] cap);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_cap = cap;
  endtask

  // receiver side
  always @(posedge clk) begin
    resp_t got, exp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{hit: out_hit, rd: out_read_value, ev: out_evicted, ev_key: out_evicted_key};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp = expected_q[0];
          expected_q.delete(0);
          if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp %p got %p", exp, got);
          end
        end
      end
      if (hold_rx) out_stall <= 1'b1;
      else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
      else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
      else if ($urandom_range(0, 3) != 0) out_stall <= 1'b0;
    end
  end

  // long receiver hold-off
  initial begin
    int n;
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    hold_rx = 1'b1;
    n = 0;
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  row_t dir_tab[$];

  function automatic row_t mk(logic cfg, logic [4:0] cap, logic op, logic [31:0] key,
                              logic [31:0] val, logic known, resp_t rsp);
    row_t t;
    t.cfg = cfg; t.cap = cap; t.op = op; t.key = key; t.val = val;
    t.known = known; t.rsp = rsp;
    return t;
  endfunction

  function automatic void add_row(row_t t);
    dir_tab.insert(dir_tab.size(), t);
  endfunction

  initial begin
    resp_t miss, none, chk;
    logic [31:0] pool [8];
    logic op;
    logic [31:0] k;
    miss = '{hit: 1'b0, rd: 32'hFFFF_FFFF, ev: 1'b0, ev_key: 32'h0};
    none = miss;
    for (int i = 0; i < NSLOT; i++) begin
      m_vld[i] = 1'b0; m_key[i] = '0; m_dat[i] = '0; m_cnt[i] = '0; m_stp[i] = '0;
    end
    m_clk = '0; m_cap = 5'd16;
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h0, 32'h0, 1'b1, miss));
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h8000_0000, 32'h0, 1'b1, miss));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, miss));
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
               '{hit: 1'b1, rd: 32'h8000_0000, ev: 1'b0, ev_key: 32'h0}));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, miss));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
               '{hit: 1'b1, rd: 32'hFFFF_FFFF, ev: 1'b0, ev_key: 32'h0}));
    add_row(mk(1'b1, 5'd2, REQ_GET, 32'h0, 32'h0, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h1, 32'h11, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h2, 32'h22, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h1, 32'h0, 1'b0, none));
    add_row(mk(1'b1, 5'd0, REQ_GET, 32'h0, 32'h0, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h3, 32'h33, 1'b1, miss));
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h3, 32'h0, 1'b1, miss));
    add_row(mk(1'b0, 5'd0, REQ_GET, 32'h8000_0000, 32'h0, 1'b0, none));
    add_row(mk(1'b1, 5'd31, REQ_GET, 32'h0, 32'h0, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h4, 32'h44, 1'b0, none));
    add_row(mk(1'b1, 5'd1, REQ_GET, 32'h0, 32'h0, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h5, 32'h55, 1'b0, none));
    add_row(mk(1'b0, 5'd0, REQ_PUT, 32'h6, 32'h66, 1'b0, none));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) set_capacity(dir_tab[i].cap);
      else begin
        send_request(dir_tab[i].op, dir_tab[i].key, dir_tab[i].val);
        chk = expected_q[$];
        if (dir_tab[i].known && chk !== dir_tab[i].rsp) begin
          errors++;
          if (errors <= 10) $display("table row %0d: predictor %p", i, chk);
        end
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case (n / 100)
          0: set_capacity(5'd16);
          1: set_capacity(5'($urandom_range(1, 15)));
          2: set_capacity(5'd4);
          default: set_capacity(5'($urandom_range(0, 31)));
        endcase
        foreach (pool[j]) pool[j] = $urandom;
      end
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) k = pool[$urandom_range(0, 7)] ^ 32'($urandom_range(0, 3));
      else k = $urandom;
      send_request(op, k, $urandom);
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
